// File: design/msa_pkg.sv
// Shared types, constants and helpers for the sensor scaler/averager.
`default_nettype none

package msa_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned HISTORY_DEPTH_DEF = 8;
  localparam int unsigned SAMPLES_DEF       = 5;

  // Field widths
  localparam int unsigned FIELD_SAMPLES = 5;
  localparam int unsigned SAMPLE_W      = 10;
  localparam int unsigned READ_W        = 19;
  localparam int unsigned MAG_W         = 18;
  localparam int unsigned VOFF_W        = 13;
  localparam int unsigned COFF_W        = 17;
  localparam int unsigned MV_W          = 15;  // millivolts incl. offset
  localparam int unsigned SC_W          = 21;  // scaled value before saturation
  localparam int unsigned NUM_CHAN      = 4;
  localparam int unsigned CHAN_W        = 2;

  // Conversion constants
  localparam int unsigned MV_SCALE        = 1000;
  localparam int unsigned MV_SHIFT        = 10;   // divide by 1024
  localparam int unsigned TEMP_BASE       = 2000;
  localparam int unsigned TEMP_SHIFT      = 2;    // divide by 4
  localparam int unsigned TEMP_ROUND      = (1 << TEMP_SHIFT) - 1;
  localparam int unsigned CUR_BASE        = 2500;
  localparam int unsigned GAIN_TEN        = 10;
  localparam int unsigned VSYS_GAIN_SHIFT = 2;    // times 4

  // APB port
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned REG_IDX_BIT = 2;

  // Pipeline depth, input register to output register
  localparam int unsigned NSTAGE = 7;

  typedef enum logic [CHAN_W-1:0] {
    CH_VSYS = 2'd0,
    CH_TEMP = 2'd1,
    CH_VBAT = 2'd2,
    CH_CURR = 2'd3
  } chan_e;

  typedef enum logic {
    REG_VOLTAGE_OFFSET = 1'b0,
    REG_CURRENT_OFFSET = 1'b1
  } reg_e;

  typedef logic signed [READ_W-1:0] reading_t;

  // Per-stage load strobes; commit marks a real request entering the history
  typedef struct packed {
    logic sum;
    logic mv;
    logic scale;
    logic hist;
    logic commit;
    logic absval;
    logic mult;
    logic outr;
  } load_t;

  function automatic reading_t sat_reading(input logic signed [SC_W-1:0] v);
    logic [SC_W-READ_W:0] hi;
    reading_t             r;
    hi = v[SC_W-1:READ_W-1];
    if (hi == '0 || hi == '1) begin
      r = reading_t'(v[READ_W-1:0]);
    end else if (v[SC_W-1]) begin
      r = {1'b1, {(READ_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(READ_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/multichannel_sensor_scaler_averager.sv
// Top level of the four-channel sensor scaler with moving-average history.
`default_nettype none

// Each request carries one reading round for one channel (up to five raw
// 10-bit ADC samples). The block converts the sample sum to millivolts
// (sum*1000/1024 plus the voltage offset register), scales it for the
// channel (system volts x4, temperature (mv-2000)/4 in 0.1 C, battery volts
// x10, current (mv-2500)*10 plus the current offset register), saturates it
// to 19 bits and pushes it into that channel's HISTORY_DEPTH-entry history.
// The result carries the new reading, the mean of the history (truncated
// toward zero) and its magnitude. A request is taken every clock cycle
// unless every stage is full and the output stalls, and the stages drain
// independently, so input ready stays high while a finished result waits
// as long as an earlier stage has room. The rate is set by the history
// stage, which reads and updates the channel's running total together, so
// requests for the same channel may follow each other directly. Histories
// and totals clear at reset (entries not yet written count as zero).
// Offsets live at byte addresses 0 and 4 of the APB port and must be
// written only while the pipeline is empty.

module multichannel_sensor_scaler_averager #(
  parameter int unsigned HISTORY_DEPTH       = msa_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned SAMPLES_PER_READING = msa_pkg::SAMPLES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // APB configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [msa_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [msa_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [msa_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready,
  // request channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [msa_pkg::CHAN_W-1:0]            channel_i,
  input  logic [msa_pkg::SAMPLE_W-1:0]          sample_a_i,
  input  logic [msa_pkg::SAMPLE_W-1:0]          sample_b_i,
  input  logic [msa_pkg::SAMPLE_W-1:0]          sample_c_i,
  input  logic [msa_pkg::SAMPLE_W-1:0]          sample_d_i,
  input  logic [msa_pkg::SAMPLE_W-1:0]          sample_e_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [msa_pkg::CHAN_W-1:0]            out_channel_o,
  output logic signed [msa_pkg::READ_W-1:0]     scaled_reading_o,
  output logic signed [msa_pkg::READ_W-1:0]     mean_value_o,
  output logic [msa_pkg::MAG_W-1:0]             mean_magnitude_o
);
  import msa_pkg::*;

  localparam int unsigned TOT_W = READ_W + $clog2(HISTORY_DEPTH);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [VOFF_W-1:0] voff_q;
  logic signed [COFF_W-1:0] coff_q;
  logic                     cfg_wr;
  reg_e                     cfg_reg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_reg = reg_e'(paddr[REG_IDX_BIT]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voff_q <= '0;
      coff_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        REG_VOLTAGE_OFFSET: voff_q <= pwdata[VOFF_W-1:0];
        REG_CURRENT_OFFSET: coff_q <= pwdata[COFF_W-1:0];
        default: ;
      endcase
    end
  end

  // reads return the sign-extended offset
  always_comb begin
    unique case (cfg_reg)
      REG_VOLTAGE_OFFSET: prdata = APB_DATA_W'(voff_q);
      REG_CURRENT_OFFSET: prdata = APB_DATA_W'(coff_q);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its
  // successor loads, so bubbles close up while the output is stalled.
  // ---------------------------------------------------------------------
  logic [NSTAGE:1] vld_q;
  logic [NSTAGE:1] adv;
  logic [NSTAGE:1] vld_in;
  load_t           load;

  always_comb begin
    adv[NSTAGE] = !vld_q[NSTAGE] || out_ready_i;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign vld_in = {vld_q[NSTAGE-1:1], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NSTAGE; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  // stage map: 1 sum, 2 mv, 3 scale, 4 history, 5 abs, 6 multiply, 7 out
  assign load.sum    = adv[1];
  assign load.mv     = adv[2];
  assign load.scale  = adv[3];
  assign load.hist   = adv[4];
  assign load.commit = adv[4] && vld_q[3];  // history state moves only here
  assign load.absval = adv[5];
  assign load.mult   = adv[6];
  assign load.outr   = adv[7];

  assign in_ready_o  = adv[1];
  assign out_valid_o = vld_q[NSTAGE];

  // ---------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------
  chan_e                   chan3, chan4;
  reading_t                scaled3, scaled4;
  logic signed [TOT_W-1:0] total4;

  msa_front #(
    .SAMPLES (SAMPLES_PER_READING)
  ) u_front (
    .clk_i            (clk_i),
    .load_i           (load),
    .channel_i        (channel_i),
    .sample_a_i       (sample_a_i),
    .sample_b_i       (sample_b_i),
    .sample_c_i       (sample_c_i),
    .sample_d_i       (sample_d_i),
    .sample_e_i       (sample_e_i),
    .voltage_offset_i (voff_q),
    .current_offset_i (coff_q),
    .chan_o           (chan3),
    .scaled_o         (scaled3)
  );

  msa_history #(
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .chan_i   (chan3),
    .scaled_i (scaled3),
    .chan_o   (chan4),
    .scaled_o (scaled4),
    .total_o  (total4)
  );

  msa_mean #(
    .DEPTH (HISTORY_DEPTH)
  ) u_mean (
    .clk_i            (clk_i),
    .load_i           (load),
    .chan_i           (chan4),
    .scaled_i         (scaled4),
    .total_i          (total4),
    .out_channel_o    (out_channel_o),
    .scaled_reading_o (scaled_reading_o),
    .mean_value_o     (mean_value_o),
    .mean_magnitude_o (mean_magnitude_o)
  );

endmodule

`default_nettype wire

// File: design/msa_front.sv
// Front end: sample sum, millivolt conversion and per-channel scaling.
`default_nettype none

module msa_front #(
  parameter int unsigned SAMPLES = msa_pkg::SAMPLES_DEF
) (
  input  logic                              clk_i,
  input  msa_pkg::load_t                    load_i,
  input  logic [msa_pkg::CHAN_W-1:0]        channel_i,
  input  logic [msa_pkg::SAMPLE_W-1:0]      sample_a_i,
  input  logic [msa_pkg::SAMPLE_W-1:0]      sample_b_i,
  input  logic [msa_pkg::SAMPLE_W-1:0]      sample_c_i,
  input  logic [msa_pkg::SAMPLE_W-1:0]      sample_d_i,
  input  logic [msa_pkg::SAMPLE_W-1:0]      sample_e_i,
  input  logic signed [msa_pkg::VOFF_W-1:0] voltage_offset_i,
  input  logic signed [msa_pkg::COFF_W-1:0] current_offset_i,
  output msa_pkg::chan_e                    chan_o,
  output msa_pkg::reading_t                 scaled_o
);
  import msa_pkg::*;

  localparam int unsigned NSAMP = (SAMPLES > FIELD_SAMPLES) ? FIELD_SAMPLES :
                                  ((SAMPLES < 1) ? 1 : SAMPLES);
  localparam int unsigned SUM_W = $clog2(NSAMP * ((1 << SAMPLE_W) - 1) + 1);
  localparam int unsigned PRD_W = SUM_W + MV_SHIFT;

  logic [SAMPLE_W-1:0] smp [FIELD_SAMPLES];
  logic [SUM_W-1:0]    sum_d, sum_q;
  chan_e               chan1_q, chan2_q, chan3_q;

  logic [PRD_W-1:0]         mvprod;
  logic signed [MV_W-1:0]   mv_d, mv_q;

  logic signed [MV_W:0]     tdiff, tbias;
  logic signed [SC_W-1:0]   cdiff, sc;
  reading_t                 scaled_d, scaled_q;

  assign smp[0] = sample_a_i;
  assign smp[1] = sample_b_i;
  assign smp[2] = sample_c_i;
  assign smp[3] = sample_d_i;
  assign smp[4] = sample_e_i;

  // stage 1: add the used sample fields
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NSAMP; i++) begin
      sum_d = sum_d + SUM_W'(smp[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.sum) begin
      sum_q   <= sum_d;
      chan1_q <= chan_e'(channel_i);
    end
  end

  // stage 2: mv = floor(sum*1000/1024) + offset
  assign mvprod = PRD_W'(sum_q) * PRD_W'(MV_SCALE);
  assign mv_d   = signed'(MV_W'(mvprod[PRD_W-1:MV_SHIFT])) + MV_W'(voltage_offset_i);

  always_ff @(posedge clk_i) begin
    if (load_i.mv) begin
      mv_q    <= mv_d;
      chan2_q <= chan1_q;
    end
  end

  // stage 3: channel scaling, temperature divide truncates toward zero
  always_comb begin
    tdiff = (MV_W+1)'(mv_q) - signed'((MV_W+1)'(TEMP_BASE));
    tbias = tdiff + signed'((MV_W+1)'(tdiff[MV_W] ? TEMP_ROUND : 0));
    cdiff = SC_W'(mv_q) - signed'(SC_W'(CUR_BASE));
    case (chan2_q)
      CH_VSYS: sc = SC_W'(mv_q) <<< VSYS_GAIN_SHIFT;
      CH_TEMP: sc = SC_W'(tbias >>> TEMP_SHIFT);
      CH_VBAT: sc = SC_W'(mv_q) * signed'(SC_W'(GAIN_TEN));
      default: sc = cdiff * signed'(SC_W'(GAIN_TEN)) + SC_W'(current_offset_i);
    endcase
    scaled_d = sat_reading(sc);
  end

  always_ff @(posedge clk_i) begin
    if (load_i.scale) begin
      scaled_q <= scaled_d;
      chan3_q  <= chan2_q;
    end
  end

  assign chan_o   = chan3_q;
  assign scaled_o = scaled_q;

endmodule

`default_nettype wire

// File: design/msa_cell.sv
// One history cell: one entry per channel, shifted from the previous cell.
`default_nettype none

module msa_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  msa_pkg::chan_e    chan_i,
  input  msa_pkg::reading_t din_i,
  output msa_pkg::reading_t dout_o
);
  import msa_pkg::*;

  reading_t entry_q [NUM_CHAN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        entry_q[i] <= '0;
      end
    end else if (shift_i) begin
      entry_q[chan_i] <= din_i;
    end
  end

  assign dout_o = entry_q[chan_i];

endmodule

`default_nettype wire

// File: design/msa_history.sv
// History chain of cells plus per-channel running totals.
`default_nettype none

module msa_history #(
  parameter int unsigned DEPTH = msa_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  msa_pkg::load_t                                       load_i,
  input  msa_pkg::chan_e                                       chan_i,
  input  msa_pkg::reading_t                                    scaled_i,
  output msa_pkg::chan_e                                       chan_o,
  output msa_pkg::reading_t                                    scaled_o,
  output logic signed [msa_pkg::READ_W+$clog2(DEPTH)-1:0]      total_o
);
  import msa_pkg::*;

  localparam int unsigned TOT_W = READ_W + $clog2(DEPTH);

  reading_t                link [DEPTH+1];
  logic signed [TOT_W-1:0] tot_q [NUM_CHAN];
  logic signed [TOT_W-1:0] tot_d, total_q;
  chan_e                   chan_q;
  reading_t                scaled_q;

  assign link[0] = scaled_i;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    msa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (load_i.commit),
      .chan_i  (chan_i),
      .din_i   (link[g]),
      .dout_o  (link[g+1])
    );
  end

  // new total: add the newest entry, drop the one falling off the end
  assign tot_d = tot_q[chan_i] + TOT_W'(scaled_i) - TOT_W'(link[DEPTH]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        tot_q[i] <= '0;
      end
    end else if (load_i.commit) begin
      tot_q[chan_i] <= tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.hist) begin
      total_q  <= tot_d;
      chan_q   <= chan_i;
      scaled_q <= scaled_i;
    end
  end

  assign total_o  = total_q;
  assign chan_o   = chan_q;
  assign scaled_o = scaled_q;

endmodule

`default_nettype wire

// File: design/msa_mean.sv
// Mean stages: magnitude, reciprocal multiply, sign restore and output register.
`default_nettype none

module msa_mean #(
  parameter int unsigned DEPTH = msa_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                            clk_i,
  input  msa_pkg::load_t                                  load_i,
  input  msa_pkg::chan_e                                  chan_i,
  input  msa_pkg::reading_t                               scaled_i,
  input  logic signed [msa_pkg::READ_W+$clog2(DEPTH)-1:0] total_i,
  output logic [msa_pkg::CHAN_W-1:0]                      out_channel_o,
  output logic signed [msa_pkg::READ_W-1:0]               scaled_reading_o,
  output logic signed [msa_pkg::READ_W-1:0]               mean_value_o,
  output logic [msa_pkg::MAG_W-1:0]                       mean_magnitude_o
);
  import msa_pkg::*;

  localparam int unsigned L     = $clog2(DEPTH);
  localparam int unsigned TOT_W = READ_W + L;
  localparam int unsigned SH    = TOT_W + L;
  localparam int unsigned RCP_W = TOT_W + 1;
  localparam int unsigned PRD_W = TOT_W + RCP_W;
  // ceil(2^SH / DEPTH): exact floor division for any dividend below 2^TOT_W
  localparam logic [63:0] RECIP64 = ((64'd1 << SH) + 64'(DEPTH) - 64'd1) / DEPTH;
  localparam logic [RCP_W-1:0] RECIP = RECIP64[RCP_W-1:0];

  logic [TOT_W-1:0]  abs_d, abs_q;
  logic              neg5_q, neg6_q;
  chan_e             chan5_q, chan6_q;
  reading_t          scaled5_q, scaled6_q;
  logic [PRD_W-1:0]  prod_q;
  logic [READ_W-1:0] quo;

  assign abs_d = total_i[TOT_W-1] ? TOT_W'(-total_i) : TOT_W'(total_i);

  always_ff @(posedge clk_i) begin
    if (load_i.absval) begin
      abs_q     <= abs_d;
      neg5_q    <= total_i[TOT_W-1];
      chan5_q   <= chan_i;
      scaled5_q <= scaled_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.mult) begin
      prod_q    <= PRD_W'(abs_q) * PRD_W'(RECIP);
      neg6_q    <= neg5_q;
      chan6_q   <= chan5_q;
      scaled6_q <= scaled5_q;
    end
  end

  assign quo = prod_q[SH +: READ_W];

  // quotient tops out at 2^18, reached only by a negative total
  always_ff @(posedge clk_i) begin
    if (load_i.outr) begin
      out_channel_o    <= chan6_q;
      scaled_reading_o <= scaled6_q;
      mean_value_o     <= neg6_q ? -signed'(quo) : signed'(quo);
      mean_magnitude_o <= quo[READ_W-1] ? {MAG_W{1'b1}} : quo[MAG_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: design/msa_checker.sv
// Port-level checks for the sensor scaler/averager, bound to the top level.
`default_nettype none

module msa_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [msa_pkg::APB_ADDR_W-1:0]    paddr,
  input logic [msa_pkg::APB_DATA_W-1:0]    pwdata,
  input logic [msa_pkg::APB_DATA_W-1:0]    prdata,
  input logic                              pready,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [msa_pkg::CHAN_W-1:0]        channel_i,
  input logic [msa_pkg::SAMPLE_W-1:0]      sample_a_i,
  input logic [msa_pkg::SAMPLE_W-1:0]      sample_b_i,
  input logic [msa_pkg::SAMPLE_W-1:0]      sample_c_i,
  input logic [msa_pkg::SAMPLE_W-1:0]      sample_d_i,
  input logic [msa_pkg::SAMPLE_W-1:0]      sample_e_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [msa_pkg::CHAN_W-1:0]        out_channel_o,
  input logic signed [msa_pkg::READ_W-1:0] scaled_reading_o,
  input logic signed [msa_pkg::READ_W-1:0] mean_value_o,
  input logic [msa_pkg::MAG_W-1:0]         mean_magnitude_o
);
  import msa_pkg::*;

  // temperature readings stay inside (mv-2000)/4 for mv in -4096..9090
  localparam logic signed [READ_W-1:0] TEMP_LO = -19'sd1524;
  localparam logic signed [READ_W-1:0] TEMP_HI = 19'sd1772;

  logic [MAG_W-1:0] mag_exp;

  always_comb begin
    if (!mean_value_o[READ_W-1]) begin
      mag_exp = mean_value_o[MAG_W-1:0];
    end else if (mean_value_o[MAG_W-1:0] == '0) begin
      mag_exp = {MAG_W{1'b1}};
    end else begin
      mag_exp = MAG_W'(-mean_value_o);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mean_value_o) &&
      $stable(scaled_reading_o) && $stable(out_channel_o))
    else $error("result changed while stalled");

  a_mag_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mean_magnitude_o == mag_exp)
    else $error("mean magnitude does not match mean");

  a_vsys_x4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_channel_o == CH_VSYS |-> scaled_reading_o[1:0] == 2'b00)
    else $error("system voltage reading not a multiple of 4");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_channel_o == CH_TEMP |->
      scaled_reading_o >= TEMP_LO && scaled_reading_o <= TEMP_HI)
    else $error("temperature reading out of range");

endmodule

bind multichannel_sensor_scaler_averager msa_checker u_msa_checker (.*);

`default_nettype wire

// File: tb/sv/tb_multichannel_sensor_scaler_averager.sv
`timescale 1ns / 1ps
// Self-checking testbench for the four-channel sensor scaler with moving-average history.
module tb_multichannel_sensor_scaler_averager;
  import msa_pkg::*;

  localparam int     HIST_DEPTH   = HISTORY_DEPTH_DEF;
  localparam int     NUM_SAMPLES  = SAMPLES_DEF;
  localparam int     DRAIN_CYCLES = NSTAGE + 4;
  localparam int     PHASE_ITEMS  = 170;
  localparam int     SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
  localparam longint READ_MAX     = (longint'(1) << (READ_W - 1)) - 1;
  localparam longint READ_MIN     = -(longint'(1) << (READ_W - 1));
  localparam longint MAG_MAX      = (longint'(1) << MAG_W) - 1;
  localparam longint VOFF_MAX     = (longint'(1) << (VOFF_W - 1)) - 1;
  localparam longint VOFF_MIN     = -(longint'(1) << (VOFF_W - 1));
  localparam longint COFF_MAX     = (longint'(1) << (COFF_W - 1)) - 1;
  localparam longint COFF_MIN     = -(longint'(1) << (COFF_W - 1));

  // One reading round as it goes into the block
  typedef struct {
    chan_e               ch;
    logic [SAMPLE_W-1:0] smp [FIELD_SAMPLES];
  } reading_req_t;

  // One averaged result as it comes out
  typedef struct packed {
    logic [CHAN_W-1:0] ch;
    logic [READ_W-1:0] scaled;
    logic [READ_W-1:0] mean;
    logic [MAG_W-1:0]  mag;
  } avg_result_t;

  // Tracks the per-channel histories and the results still owed by the block.
  class avg_tracker;
    longint      hist [NUM_CHAN][HIST_DEPTH];
    longint      volt_off;
    longint      cur_off;
    avg_result_t expected_avgs [$];
    int          errors;

    function new();
      foreach (hist[c, i]) hist[c][i] = 0;
      volt_off = 0;
      cur_off  = 0;
      errors   = 0;
    endfunction

    function void set_offsets(longint voff, longint coff);
      volt_off = voff;
      cur_off  = coff;
    endfunction

    function longint clamp_reading(longint v);
      if (v > READ_MAX) return READ_MAX;
      if (v < READ_MIN) return READ_MIN;
      return v;
    endfunction

    // Called once per accepted request: convert, scale, push, average.
    function void note_reading(reading_req_t r);
      int          n;
      longint      raw_sum, mv, scaled, total, mean, mag;
      avg_result_t res;
      n = NUM_SAMPLES;
      if (n > FIELD_SAMPLES) n = FIELD_SAMPLES;
      if (n < 1) n = 1;
      raw_sum = 0;
      for (int i = 0; i < n; i++) raw_sum += r.smp[i];
      // sum is never negative, so the divide is a plain floor
      mv = (raw_sum * 1000) / 1024 + volt_off;
      case (r.ch)
        CH_VSYS: scaled = mv * 4;
        CH_TEMP: scaled = (mv - 2000) / 4;  // truncates toward zero
        CH_VBAT: scaled = mv * 10;
        default: scaled = (mv - 2500) * 10 + cur_off;
      endcase
      scaled = clamp_reading(scaled);
      for (int i = HIST_DEPTH - 1; i > 0; i--) hist[r.ch][i] = hist[r.ch][i-1];
      hist[r.ch][0] = scaled;
      total = 0;
      for (int i = 0; i < HIST_DEPTH; i++) total += hist[r.ch][i];
      mean = clamp_reading(total / HIST_DEPTH);
      mag  = (mean < 0) ? -mean : mean;
      if (mag > MAG_MAX) mag = MAG_MAX;
      res.ch     = r.ch;
      res.scaled = scaled[READ_W-1:0];
      res.mean   = mean[READ_W-1:0];
      res.mag    = mag[MAG_W-1:0];
      expected_avgs.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [CHAN_W-1:0] ch, logic [READ_W-1:0] scaled,
                               logic [READ_W-1:0] mean, logic [MAG_W-1:0] mag);
      avg_result_t want;
      if (expected_avgs.size() == 0) begin
        $display("%0t: unexpected result, expected none, got ch %0d scaled %0h mean %0h mag %0h",
                 $time, ch, scaled, mean, mag);
        errors++;
        return;
      end
      want = expected_avgs.pop_front();
      compare_field("out_channel", want.ch, ch);
      compare_field("scaled_reading", want.scaled, scaled);
      compare_field("mean_value", want.mean, mean);
      compare_field("mean_magnitude", want.mag, mag);
    endfunction
  endclass

  // Clock, reset and block ports; every driven input known from time zero
  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  psel             = 1'b0;
  logic                  penable          = 1'b0;
  logic                  pwrite           = 1'b0;
  logic [APB_ADDR_W-1:0] paddr            = '0;
  logic [APB_DATA_W-1:0] pwdata           = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i       = 1'b0;
  logic                  in_ready_o;
  logic [CHAN_W-1:0]     channel_i        = '0;
  logic [SAMPLE_W-1:0]   sample_a_i       = '0;
  logic [SAMPLE_W-1:0]   sample_b_i       = '0;
  logic [SAMPLE_W-1:0]   sample_c_i       = '0;
  logic [SAMPLE_W-1:0]   sample_d_i       = '0;
  logic [SAMPLE_W-1:0]   sample_e_i       = '0;
  logic                  out_valid_o;
  logic                  out_ready_i      = 1'b0;
  logic [CHAN_W-1:0]     out_channel_o;
  logic [READ_W-1:0]     scaled_reading_o;
  logic [READ_W-1:0]     mean_value_o;
  logic [MAG_W-1:0]      mean_magnitude_o;

  avg_tracker   tracker = new();
  reading_req_t req_q [$];
  int           send_idle_pct = 0;  // chance per cycle that the sender holds off
  int           stall_pct     = 0;  // chance per cycle that the receiver stalls

  multichannel_sensor_scaler_averager #(
    .HISTORY_DEPTH      (HISTORY_DEPTH_DEF),
    .SAMPLES_PER_READING(SAMPLES_DEF)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .channel_i       (channel_i),
    .sample_a_i      (sample_a_i),
    .sample_b_i      (sample_b_i),
    .sample_c_i      (sample_c_i),
    .sample_d_i      (sample_d_i),
    .sample_e_i      (sample_e_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_channel_o   (out_channel_o),
    .scaled_reading_o(scaled_reading_o),
    .mean_value_o    (mean_value_o),
    .mean_magnitude_o(mean_magnitude_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Result side: check at the edge where the handshake completes (pre-edge
  // values), then pick the ready for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_result(out_channel_o, scaled_reading_o, mean_value_o, mean_magnitude_o);
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Sample near a burst's base level, with the odd extreme or wild value.
  function automatic logic [SAMPLE_W-1:0] pick_sample(int base);
    int v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = SAMPLE_MAX;
      2, 3:    v = $urandom_range(0, SAMPLE_MAX);
      default: v = base + $urandom_range(0, 32) - 16;
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  function automatic void queue_reading(chan_e ch, int a, int b, int c, int d, int e);
    reading_req_t r;
    r.ch     = ch;
    r.smp[0] = SAMPLE_W'(a);
    r.smp[1] = SAMPLE_W'(b);
    r.smp[2] = SAMPLE_W'(c);
    r.smp[3] = SAMPLE_W'(d);
    r.smp[4] = SAMPLE_W'(e);
    req_q.push_back(r);
  endfunction

  // Mostly runs on one channel at a steady level, so the history fills and
  // the mean settles; a stray channel now and then breaks the run.
  function automatic void queue_bursts(int n_items);
    int           left, len, base;
    chan_e        ch;
    reading_req_t r;
    left = n_items;
    while (left > 0) begin
      ch   = chan_e'($urandom_range(0, NUM_CHAN - 1));
      len  = $urandom_range(1, 12);
      base = $urandom_range(0, SAMPLE_MAX);
      if (len > left) len = left;
      repeat (len) begin
        r.ch = ch;
        if ($urandom_range(0, 9) == 0) r.ch = chan_e'($urandom_range(0, NUM_CHAN - 1));
        foreach (r.smp[i]) r.smp[i] = pick_sample(base);
        req_q.push_back(r);
      end
      left -= len;
    end
  endfunction

  // Push every queued request through the input handshake. Valid is only
  // dropped when a gap follows, so back-to-back requests keep it high.
  task automatic drive_requests();
    reading_req_t r;
    int           gap;
    while (req_q.size() > 0) begin
      r   = req_q.pop_front();
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if ($urandom_range(0, 63) == 0) begin
        // hold off until the block has handed back everything it owes
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (tracker.expected_avgs.size() != 0) @(posedge clk_i);
      end else if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      channel_i  <= r.ch;
      sample_a_i <= r.smp[0];
      sample_b_i <= r.smp[1];
      sample_c_i <= r.smp[2];
      sample_d_i <= r.smp[3];
      sample_e_i <= r.smp[4];
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      tracker.note_reading(r);
    end
    in_valid_i <= 1'b0;
  endtask

  // Setup and access phases, then idle with psel low so back-to-back writes stay apart.
  task automatic apb_write(reg_e idx, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx) << REG_IDX_BIT;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_for_drain();
    while (tracker.expected_avgs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Offsets change only with the pipeline empty.
  task automatic apply_offsets(longint voff, longint coff);
    wait_for_drain();
    apb_write(REG_VOLTAGE_OFFSET, APB_DATA_W'(voff));
    apb_write(REG_CURRENT_OFFSET, APB_DATA_W'(coff));
    tracker.set_offsets(voff, coff);
  endtask

  task automatic run_phase(int idle, int stall, longint voff, longint coff);
    apply_offsets(voff, coff);
    send_idle_pct = idle;
    stall_pct     = stall;
    queue_bursts(PHASE_ITEMS);
    drive_requests();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty and full-scale rounds on every channel with zero offsets
    queue_reading(CH_VSYS, 0, 0, 0, 0, 0);
    queue_reading(CH_TEMP, 0, 0, 0, 0, 0);
    queue_reading(CH_VBAT, 0, 0, 0, 0, 0);
    queue_reading(CH_CURR, 0, 0, 0, 0, 0);
    queue_reading(CH_VSYS, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    queue_reading(CH_TEMP, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    queue_reading(CH_VBAT, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    queue_reading(CH_CURR, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    // only the first or only the last field set: all five fields are summed
    queue_reading(CH_TEMP, SAMPLE_MAX, 0, 0, 0, 0);
    queue_reading(CH_CURR, 0, 0, 0, 0, SAMPLE_MAX);
    // temperature just below 2000 mV: -3/4 and -7/4 must truncate toward zero
    queue_reading(CH_TEMP, 409, 409, 409, 409, 409);
    queue_reading(CH_TEMP, 409, 409, 409, 409, 405);
    drive_requests();

    // Largest offsets with full-scale samples, then smallest with empty ones
    apply_offsets(VOFF_MAX, COFF_MAX);
    queue_reading(CH_VSYS, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    queue_reading(CH_TEMP, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    queue_reading(CH_VBAT, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    queue_reading(CH_CURR, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    drive_requests();
    apply_offsets(VOFF_MIN, COFF_MIN);
    queue_reading(CH_VSYS, 0, 0, 0, 0, 0);
    queue_reading(CH_TEMP, 0, 0, 0, 0, 0);
    queue_reading(CH_VBAT, 0, 0, 0, 0, 0);
    queue_reading(CH_CURR, 0, 0, 0, 0, 0);
    drive_requests();

    // Random phases: free flowing, slow sender, slow receiver, both
    run_phase(0, 0, $signed(VOFF_W'($urandom)), $signed(COFF_W'($urandom)));
    run_phase(70, 0, $signed(VOFF_W'($urandom)), $signed(COFF_W'($urandom)));
    run_phase(0, 70, VOFF_MAX, COFF_MIN);
    run_phase(33, 33, VOFF_MIN, COFF_MAX);

    wait_for_drain();
    if (tracker.errors == 0 && tracker.expected_avgs.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
design/msa_pkg.sv
design/msa_front.sv
design/msa_cell.sv
design/msa_history.sv
design/msa_mean.sv
design/multichannel_sensor_scaler_averager.sv
design/msa_checker.sv
tb/sv/tb_multichannel_sensor_scaler_averager.sv
